/* sv/isort_pkg.sv */
// Shared types for the insertion sorter: controller states and the
// command/status bundles between controller and datapath. No dependencies.
package isort_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic load;     // take input item, start insertion or mark overflow
        logic shift;    // move entry at pos-1 up to pos
        logic place;    // write key at pos, bump fill count
        logic capture;  // register store read data into output stage
        logic advance;  // next output entry
        logic finish;   // set given out, empty the store
    } cmd_t;

    typedef struct packed {
        logic full;       // store holds CAPACITY entries
        logic pos_zero;   // insertion point reached the bottom
        logic greater;    // entry below pos is larger than the key
        logic key_last;   // item being inserted closes the set
        logic out_end;    // output entry is the final one of the set
    } status_t;

endpackage

/* sv/insertion_sorter.sv */
// Insertion sorter top level. An item is accepted, then inserted by moving
// each larger stored entry up one place before the key is written, one store
// shift per cycle through the single-port-write memory.
// On the set's last item, each result goes through read, load and send states.
// Synchronous active-low reset empties the store (fill count and overflow
// cleared); store contents are not cleared.
module insertion_sorter #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_sorted_value,
    output logic                         m_end_of_set,
    output logic                         m_truncated
);
    isort_pkg::cmd_t    cmd;
    isort_pkg::status_t status;

    isort_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    isort_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_value),
        .in_last   (s_last),
        .out_value (m_sorted_value),
        .out_end   (m_end_of_set),
        .out_trunc (m_truncated)
    );

    // input and output sides never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // a set in progress keeps the input closed
    a_set_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_end_of_set) |=> !s_ready)
        else $error("input reopened before end of set");

    // end of set returns straight to accepting input
    a_set_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_set) |=> (s_ready && !m_valid))
        else $error("sorter did not return to idle after end of set");

endmodule

/* sv/isort_datapath.sv */
// Insertion sorter datapath: sorted store memory, insertion pointer,
// fill count, overflow flag and output register. Uses isort_pkg.
module isort_datapath #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  isort_pkg::cmd_t              cmd,
    output isort_pkg::status_t           status,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  logic                         in_last,
    output logic signed [VALUE_BITS-1:0] out_value,
    output logic                         out_end,
    output logic                         out_trunc
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_BITS-1:0] store_mem [CAPACITY];
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]                rd_addr;

    logic signed [VALUE_BITS-1:0] key_reg;
    logic                         last_reg;
    logic [AW-1:0]                pos_reg,   pos_next;
    logic [CW-1:0]                fill_reg,  fill_next;
    logic                         ovf_reg,   ovf_next;
    logic [AW-1:0]                oidx_reg,  oidx_next;
    logic signed [VALUE_BITS-1:0] oval_reg;
    logic                         oend_reg;
    logic                         otrunc_reg;

    logic full;
    assign full = (fill_reg == CW'(CAPACITY));

    // Read port: next entry below the insertion point, or the output entry.
    // Addresses that wrap at the bottom are never consumed.
    always_comb begin
        if (cmd.load) begin
            rd_addr = AW'(fill_reg - CW'(1));
        end else if (cmd.shift) begin
            rd_addr = pos_reg - AW'(2);
        end else begin
            rd_addr = oidx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= store_mem[rd_addr];
        if (cmd.shift) begin
            store_mem[pos_reg] <= rd_data_reg;
        end else if (cmd.place) begin
            store_mem[pos_reg] <= key_reg;
        end
    end

    always_comb begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        oidx_next = oidx_reg;
        if (cmd.load) begin
            pos_next = fill_reg[AW-1:0];
            if (full) begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.shift) begin
            pos_next = pos_reg - AW'(1);
        end
        if (cmd.place) begin
            fill_next = fill_reg + CW'(1);
        end
        if (cmd.advance) begin
            oidx_next = oidx_reg + AW'(1);
        end
        if (cmd.finish) begin
            fill_next = '0;
            ovf_next  = 1'b0;
            oidx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
            oidx_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            oidx_reg <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg  <= in_value;
            last_reg <= in_last;
        end
        if (cmd.capture) begin
            oval_reg   <= rd_data_reg;
            oend_reg   <= status.out_end;
            otrunc_reg <= ovf_reg;
        end
    end

    assign status.full     = full;
    assign status.pos_zero = (pos_reg == '0);
    assign status.greater  = (rd_data_reg > key_reg);
    assign status.key_last = last_reg;
    assign status.out_end  = ((CW'(oidx_reg) + CW'(1)) == fill_reg);

    assign out_value = oval_reg;
    assign out_end   = oend_reg;
    assign out_trunc = otrunc_reg;

endmodule

/* sv/isort_ctrl.sv */
// Insertion sorter controller: sequences insertion shifts and the output
// sweep over the store. Uses isort_pkg.
module isort_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  isort_pkg::status_t  status,
    output isort_pkg::cmd_t     cmd
);
    isort_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= isort_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            isort_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (!status.full) begin
                        state_next = isort_pkg::ST_SHIFT;
                    end else if (s_last) begin
                        // dropped item still closes the set
                        state_next = isort_pkg::ST_READ;
                    end
                end
            end
            isort_pkg::ST_SHIFT: begin
                if (!status.pos_zero && status.greater) begin
                    cmd.shift = 1'b1;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = status.key_last ? isort_pkg::ST_READ
                                                 : isort_pkg::ST_IDLE;
                end
            end
            isort_pkg::ST_READ: begin
                state_next = isort_pkg::ST_LOAD;
            end
            isort_pkg::ST_LOAD: begin
                cmd.capture = 1'b1;
                state_next  = isort_pkg::ST_SEND;
            end
            isort_pkg::ST_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.out_end) begin
                        cmd.finish = 1'b1;
                        state_next = isort_pkg::ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = isort_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = isort_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* tb/sv/insertion_sorter_checker.sv */
// Scoreboard for insertion_sorter: watches both channels, keeps its own sorted
// store, queues the results each closed set owes and compares every result transfer.
// Depends only on the DUT port list; no package types are needed.
module insertion_sorter_checker #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    input  logic                         s_last,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [VALUE_BITS-1:0] m_sorted_value,
    input  logic                         m_end_of_set,
    input  logic                         m_truncated,
    output int                           mismatch_count,
    output int                           results_owed
);

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic                         end_of_set;
        logic                         truncated;
    } sorted_result_t;

    logic signed [VALUE_BITS-1:0] sort_store [CAPACITY];
    int                           store_fill;
    logic                         set_truncated;
    sorted_result_t               owed_q [$];

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
        store_fill     = 0;
        set_truncated  = 1'b0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Insert one element; strict compare keeps equal values in arrival order.
    // A closed set queues its whole sorted contents and empties the store.
    task automatic absorb_element(input logic signed [VALUE_BITS-1:0] value,
                                  input logic last);
        int             pos;
        sorted_result_t res;
        if (store_fill < CAPACITY) begin
            pos = store_fill;
            while (pos > 0 && sort_store[pos-1] > value) begin
                sort_store[pos] = sort_store[pos-1];
                pos--;
            end
            sort_store[pos] = value;
            store_fill++;
        end else begin
            set_truncated = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < store_fill; k++) begin
                res.value      = sort_store[k];
                res.end_of_set = (k == store_fill - 1);
                res.truncated  = set_truncated;
                owed_q.push_back(res);
            end
            store_fill    = 0;
            set_truncated = 1'b0;
        end
    endtask

    task automatic check_result();
        sorted_result_t want;
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing owed", m_sorted_value));
        end else begin
            want = owed_q.pop_front();
            if (m_sorted_value !== want.value)
                report_mismatch($sformatf("sorted_value got %0d want %0d",
                                          m_sorted_value, want.value));
            if (m_end_of_set !== want.end_of_set)
                report_mismatch($sformatf("end_of_set got %b want %b (value %0d)",
                                          m_end_of_set, want.end_of_set, want.value));
            if (m_truncated !== want.truncated)
                report_mismatch($sformatf("truncated got %b want %b (value %0d)",
                                          m_truncated, want.truncated, want.value));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            store_fill    = 0;
            set_truncated = 1'b0;
            owed_q.delete();
        end else begin
            if (s_valid && s_ready) absorb_element(s_value, s_last);
            if (m_valid && m_ready) check_result();
        end
        results_owed <= owed_q.size();
    end

endmodule

/* tb/sv/insertion_sorter_tb.sv */
// Testbench top for insertion_sorter: clock, reset, set stimulus and output
// backpressure. Depends on insertion_sorter and insertion_sorter_checker.
module insertion_sorter_tb;

    localparam int CAPACITY    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 80;
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    // per-phase idle percentages: none, sender only, receiver only, both
    localparam int SEND_IDLE  [4] = '{0, 60, 0, 24};
    localparam int RECV_STALL [4] = '{0, 0, 60, 24};

    logic                         aclk    = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [VALUE_BITS-1:0] s_value = '0;
    logic                         s_last  = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [VALUE_BITS-1:0] m_sorted_value;
    logic                         m_end_of_set;
    logic                         m_truncated;

    int mismatch_count;
    int results_owed;
    int elements_sent = 0;
    int send_idle     = 0;
    int recv_stall    = 0;
    bit hold_req      = 1'b0;

    logic signed [VALUE_BITS-1:0] mixed_set [10] =
        '{3, -2, VAL_MAX, 0, VAL_MIN, -1, 3, 1, -2, VAL_MAX - 1};
    logic signed [VALUE_BITS-1:0] rising_set [5]  = '{-3, -2, -1, 0, 1};
    logic signed [VALUE_BITS-1:0] falling_set [5] = '{VAL_MAX, 100, 0, -100, VAL_MIN};

    insertion_sorter #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_end_of_set   (m_end_of_set),
        .m_truncated    (m_truncated)
    );

    insertion_sorter_checker #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) sort_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_end_of_set   (m_end_of_set),
        .m_truncated    (m_truncated),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Output side: random stalls, or one long hold-off when requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Called at a rising edge; returns at the edge of the transfer or after the gap.
    // Valid stays high into the next call when no gap is taken.
    task automatic send_item(input logic signed [VALUE_BITS-1:0] value, input logic last);
        s_valid <= 1'b1;
        s_value <= value;
        s_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        elements_sent++;
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // extremes, near-zero values that repeat often, and full-range random
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int near_zero;
        near_zero = int'($urandom_range(15)) - 8;
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            3:       return -1;
            4, 5:    return near_zero;
            default: return $urandom;
        endcase
    endfunction

    // mostly short sets, some long ones, a few that fill or overrun the store
    function automatic int pick_set_len();
        int r;
        r = $urandom_range(99);
        if (r < 8) return CAPACITY + int'($urandom_range(3));
        if (r < 16) return int'($urandom_range(CAPACITY, 9));
        return int'($urandom_range(8, 1));
    endfunction

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++) send_item(pick_value(), i == len - 1);
    endtask

    initial begin
        int quota_base;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-element sets at both extremes
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b1);
        // duplicates, extremes and zero in scrambled order
        foreach (mixed_set[i]) send_item(mixed_set[i], i == 9);
        // already sorted, then reverse sorted
        foreach (rising_set[i]) send_item(rising_set[i], i == 4);
        foreach (falling_set[i]) send_item(falling_set[i], i == 4);

        quota_base = elements_sent;
        for (int phase = 0; phase < 4; phase++) begin
            send_idle  = SEND_IDLE[phase];
            recv_stall = RECV_STALL[phase];
            if (phase == 0) begin
                // exactly full store, no drop
                send_set(CAPACITY);
                // overrun with the closing element itself dropped; then hold the
                // output off while the next set is offered so the input backs up
                send_set(CAPACITY + 3);
                hold_req = 1'b1;
                send_set(12);
            end
            while (elements_sent < quota_base + PHASE_ITEMS * (phase + 1))
                send_set(pick_set_len());
        end
        s_valid <= 1'b0;

        // let the checker register the last closed set before polling
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (CAPACITY + 8) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
